// File: hdl/eqc_pkg.sv
// Shared types, widths, constants and the arc table of the cubemap address generator.
package eqc_pkg;

    localparam int DEF_MAX_WIDTH    = 8192;
    localparam int DEF_ANGLE_BITS   = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int CFG_W_W  = 14;
    localparam int CFG_H_W  = 13;
    localparam int ROT_W    = 16;
    localparam int FACE_W   = 3;
    localparam int PIX_W    = 11;
    localparam int SCOL_W   = 13;
    localparam int SROW_W   = 12;
    localparam int FSZ_W    = CFG_W_W - 2;
    localparam int PRESCALE = 8;
    localparam int V_W      = FSZ_W + PRESCALE + 1;
    localparam int SQ_W     = 2 * V_W;
    localparam int SQ_STAGES = V_W;
    localparam int C_W      = V_W + 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Fixed stages around the two CORDIC lanes: input, square, sum, root,
    // quadrant, combine, scale, clamp.
    localparam int PIPE_FIXED = SQ_STAGES + 7;

    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_ROTATION_ANGLE = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH = 4'd0;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [31:0] ARC_TABLE [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
        logic [PIX_W-1:0]      dst_row;
        logic                  zero;
    } eqc_vec_t;

    typedef struct packed {
        logic [PIX_W-1:0] dst_row;
        logic             zero;
    } eqc_ctl_t;

    // Arc step i in units of 2^-ab turn, rounded half up.
    function automatic logic [31:0] arc_step(input int i, input int ab);
        logic [32:0] e;
        begin
            if (i >= 24)
            begin
                return 32'd0;
            end
            e = {1'b0, ARC_TABLE[i]} + (33'd1 << (31 - ab));
            return 32'(e >> (32 - ab));
        end
    endfunction

endpackage

// File: hdl/eqc_cordic.sv
// Pipelined vectoring CORDIC: quadrant fold then one micro-rotation per stage.
module eqc_cordic
    import eqc_pkg::*;
#(
    parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    localparam int A_W = ANGLE_BITS + 2
)
(
    input  logic                  clk,
    input  logic signed [C_W-1:0] x_in,
    input  logic signed [C_W-1:0] y_in,
    input  logic                  zero_in,
    output logic signed [A_W-1:0] acc_out
);

    localparam logic signed [A_W-1:0] QTR = A_W'(1) <<< (ANGLE_BITS - 2);

    logic signed [C_W-1:0] x_reg   [0:CORDIC_STEPS];
    logic signed [C_W-1:0] y_reg   [0:CORDIC_STEPS];
    logic signed [A_W-1:0] acc_reg [0:CORDIC_STEPS];
    logic                  zero_reg [0:CORDIC_STEPS];

    logic signed [C_W-1:0] x0_next;
    logic signed [C_W-1:0] y0_next;
    logic signed [A_W-1:0] acc0_next;

    // Fold the left half-plane onto the right.
    always_comb
    begin
        x0_next   = x_in;
        y0_next   = y_in;
        acc0_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0_next   = y_in;
                y0_next   = -x_in;
                acc0_next = QTR;
            end
            else
            begin
                x0_next   = -y_in;
                y0_next   = x_in;
                acc0_next = -QTR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        acc_reg[0]  <= acc0_next;
        zero_reg[0] <= zero_in;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic [31:0]           TV = arc_step(i, ANGLE_BITS);
        localparam logic signed [A_W-1:0] TI = A_W'(TV);

        logic signed [C_W-1:0] dx;
        logic signed [C_W-1:0] dy;
        logic signed [C_W-1:0] x_next;
        logic signed [C_W-1:0] y_next;
        logic signed [A_W-1:0] acc_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] >= 0)
            begin
                x_next   = x_reg[i] + dx;
                y_next   = y_reg[i] - dy;
                acc_next = acc_reg[i] + TI;
            end
            else
            begin
                x_next   = x_reg[i] - dx;
                y_next   = y_reg[i] + dy;
                acc_next = acc_reg[i] - TI;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            acc_reg[i+1]  <= acc_next;
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    // A zero vector has no angle: drop the accumulated steps.
    assign acc_out = zero_reg[CORDIC_STEPS] ? '0 : acc_reg[CORDIC_STEPS];

endmodule

// File: hdl/equirect_to_cubemap_sample_address.sv
// Top level: cubemap pixel to equirectangular sample address, fully pipelined.
// Path: after start is taken, the done strobe passes the input, square, sum and root
//   stages, the CORDIC lanes, then combine, scale and clamp; the root and CORDIC chains are the long part.
// Throughput: one item per cycle, every cycle; busy is never raised.
// Reset: rst_n clears all valid bits and loads the register defaults
//   (width 4096, height 2048, rotation 0); in-flight items are dropped.
// Results cannot be held off: each shows for one cycle with done high.
module equirect_to_cubemap_sample_address
    import eqc_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int ANGLE_BITS   = DEF_ANGLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FACE_W-1:0] face,
    input  logic [PIX_W-1:0]  col,
    input  logic [PIX_W-1:0]  row,
    output logic              done,
    output logic [SCOL_W-1:0] src_col,
    output logic [SROW_W-1:0] src_row,
    output logic [PIX_W-1:0]  dst_row,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int A_W    = ANGLE_BITS + 2;
    localparam int L_W    = A_W + 1;
    localparam int RP_W   = ROT_W + ANGLE_BITS + 2;
    localparam int MX_W   = CFG_W_W + ANGLE_BITS + 4;
    localparam int P_LAST = 2 + SQ_STAGES;

    localparam logic signed [L_W-1:0]  TURN_L  = L_W'(1) <<< ANGLE_BITS;
    localparam logic signed [MX_W-1:0] TURN_M  = MX_W'(1) <<< ANGLE_BITS;
    localparam logic signed [MX_W-1:0] RND_M   = (MX_W'(1) <<< (ANGLE_BITS + 1)) - MX_W'(1);
    localparam logic signed [MX_W-1:0] COL_CAP = MX_W'(MAX_WIDTH - 1);
    localparam logic signed [MX_W-1:0] ROW_CAP = MX_W'(MAX_WIDTH / 2 - 1);
    localparam logic signed [RP_W-1:0] ROT_RND = RP_W'(65535);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [ROT_W-1:0]   rot_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_W'(4096);
            height_reg <= CFG_H_W'(2048);
            rot_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:    width_reg  <= pwdata[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= pwdata[CFG_H_W-1:0];
                REG_ROTATION_ANGLE: rot_reg    <= pwdata[ROT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:    prdata = DATA_W'(width_reg);
            REG_IMAGE_HEIGHT:   prdata = DATA_W'(height_reg);
            REG_ROTATION_ANGLE: prdata = DATA_W'(rot_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Stage A: pixel centre to cube vector
    // ---------------------------------------------------------------------
    logic [FSZ_W-1:0]       fsz;
    logic signed [13:0]     a_d;
    logic signed [13:0]     b_d;
    logic signed [V_W-1:0]  a_v;
    logic signed [V_W-1:0]  b_v;
    logic signed [V_W-1:0]  s_v;
    eqc_vec_t               vec_next;
    logic                   accept;

    assign fsz    = width_reg[CFG_W_W-1:2];
    assign accept = start && !busy;

    always_comb
    begin
        a_d = $signed({2'b00, col, 1'b1}) - $signed({2'b00, fsz});
        b_d = $signed({2'b00, row, 1'b1}) - $signed({2'b00, fsz});
        a_v = V_W'(a_d) <<< PRESCALE;
        b_v = V_W'(b_d) <<< PRESCALE;
        s_v = $signed(V_W'({1'b0, fsz})) <<< PRESCALE;
        vec_next.dst_row = PIX_W'(fsz) - PIX_W'(1) - row;
        vec_next.zero    = (fsz == '0);
        case (face)
            FACE_NX:
            begin
                vec_next.vx = -a_v; vec_next.vy = s_v;  vec_next.vz = -b_v;
            end
            FACE_PY:
            begin
                vec_next.vx = b_v;  vec_next.vy = -a_v; vec_next.vz = -s_v;
            end
            FACE_NY:
            begin
                vec_next.vx = -b_v; vec_next.vy = -a_v; vec_next.vz = s_v;
            end
            FACE_PZ:
            begin
                vec_next.vx = -s_v; vec_next.vy = -a_v; vec_next.vz = -b_v;
            end
            FACE_NZ:
            begin
                vec_next.vx = s_v;  vec_next.vy = a_v;  vec_next.vz = -b_v;
            end
            default:
            begin
                // +X, and the two unused codes
                vec_next.vx = a_v;  vec_next.vy = -s_v; vec_next.vz = -b_v;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Vector payload and valid bits through squares, sum and root stages
    // ---------------------------------------------------------------------
    eqc_vec_t         p_reg [0:P_LAST];
    logic [P_LAST:0]  v_reg;

    always_ff @(posedge clk)
    begin
        p_reg[0] <= vec_next;
        for (int k = 1; k <= P_LAST; k++)
        begin
            p_reg[k] <= p_reg[k-1];
        end
    end

    // Stage B: squares
    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic signed [SQ_W-1:0] sqx_next;
    logic signed [SQ_W-1:0] sqy_next;

    always_comb
    begin
        sqx_next = SQ_W'(p_reg[0].vx) * SQ_W'(p_reg[0].vx);
        sqy_next = SQ_W'(p_reg[0].vy) * SQ_W'(p_reg[0].vy);
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
    end

    // Stage C onward: restoring square root, one result bit per stage
    logic [SQ_W-1:0] rn_reg [0:SQ_STAGES];
    logic [SQ_W-1:0] rr_reg [0:SQ_STAGES];

    always_ff @(posedge clk)
    begin
        rn_reg[0] <= sqx_reg + sqy_reg;
        rr_reg[0] <= '0;
    end

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_root
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STAGES - 1 - j));

        logic [SQ_W:0]   trial;
        logic [SQ_W-1:0] n_next;
        logic [SQ_W-1:0] r_next;

        always_comb
        begin
            trial = {1'b0, rr_reg[j]} + {1'b0, BITV};
            if ({1'b0, rn_reg[j]} >= trial)
            begin
                n_next = rn_reg[j] - trial[SQ_W-1:0];
                r_next = (rr_reg[j] >> 1) + BITV;
            end
            else
            begin
                n_next = rn_reg[j];
                r_next = rr_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            rn_reg[j+1] <= n_next;
            rr_reg[j+1] <= r_next;
        end
    end

    // ---------------------------------------------------------------------
    // Longitude and latitude CORDIC lanes, side by side
    // ---------------------------------------------------------------------
    logic signed [C_W-1:0] lon_x;
    logic signed [C_W-1:0] lon_y;
    logic signed [C_W-1:0] lat_x;
    logic signed [C_W-1:0] lat_y;
    logic                  lon_zero;
    logic                  lat_zero;
    logic signed [A_W-1:0] lon_acc;
    logic signed [A_W-1:0] lat_acc;

    assign lon_x    = C_W'(p_reg[P_LAST].vx);
    assign lon_y    = C_W'(p_reg[P_LAST].vy);
    assign lat_x    = C_W'(p_reg[P_LAST].vz);
    assign lat_y    = $signed(C_W'({1'b0, rr_reg[SQ_STAGES][V_W-1:0]}));
    assign lon_zero = (p_reg[P_LAST].vx == '0) && (p_reg[P_LAST].vy == '0);
    assign lat_zero = (rr_reg[SQ_STAGES] == '0) && (p_reg[P_LAST].vz == '0);

    eqc_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lon (
        .clk     (clk),
        .x_in    (lon_x),
        .y_in    (lon_y),
        .zero_in (lon_zero),
        .acc_out (lon_acc)
    );

    eqc_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_lat (
        .clk     (clk),
        .x_in    (lat_x),
        .y_in    (lat_y),
        .zero_in (lat_zero),
        .acc_out (lat_acc)
    );

    // Hold the flipped row and the zero-face flag alongside the lanes.
    eqc_ctl_t              d_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] dv_reg;

    always_ff @(posedge clk)
    begin
        d_reg[0].dst_row <= p_reg[P_LAST].dst_row;
        d_reg[0].zero    <= p_reg[P_LAST].zero;
        for (int k = 1; k <= CORDIC_STEPS; k++)
        begin
            d_reg[k] <= d_reg[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // Combine: add rotation, wrap longitude into one turn keeping its sign
    // ---------------------------------------------------------------------
    logic signed [RP_W-1:0] rot_prod;
    logic signed [RP_W-1:0] rot_adj;
    logic signed [A_W-1:0]  rot_turn;
    logic signed [L_W-1:0]  lon_sum;
    logic signed [L_W-1:0]  lon_next;
    logic signed [L_W-1:0]  lon_reg;
    logic signed [A_W-1:0]  lat_reg;
    eqc_ctl_t               cmb_reg;
    logic                   cmb_v_reg;

    always_comb
    begin
        rot_prod = RP_W'($signed(rot_reg)) <<< ANGLE_BITS;
        rot_adj  = (rot_prod < 0) ? rot_prod + ROT_RND : rot_prod;
        rot_turn = rot_adj[A_W+15:16];
        lon_sum  = L_W'(lon_acc) + L_W'(rot_turn);
        if (lon_sum >= TURN_L)
        begin
            lon_next = lon_sum - TURN_L;
        end
        else if (lon_sum <= -TURN_L)
        begin
            lon_next = lon_sum + TURN_L;
        end
        else
        begin
            lon_next = lon_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        lon_reg <= lon_next;
        lat_reg <= lat_acc;
        cmb_reg <= d_reg[CORDIC_STEPS];
    end

    // ---------------------------------------------------------------------
    // Scale: angle times image size, less one turn
    // ---------------------------------------------------------------------
    logic signed [MX_W-1:0] px_reg;
    logic signed [MX_W-1:0] py_reg;
    logic signed [MX_W-1:0] px_next;
    logic signed [MX_W-1:0] py_next;
    eqc_ctl_t               mul_reg;
    logic                   mul_v_reg;

    always_comb
    begin
        px_next = MX_W'($signed({1'b0, width_reg, 1'b0})) * MX_W'(lon_reg) - TURN_M;
        py_next = MX_W'($signed({1'b0, height_reg, 2'b00})) * MX_W'(lat_reg) - TURN_M;
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        mul_reg <= cmb_reg;
    end

    // ---------------------------------------------------------------------
    // Output: divide by two turns toward zero, clamp to the image
    // ---------------------------------------------------------------------
    logic signed [MX_W-1:0] qx;
    logic signed [MX_W-1:0] qy;
    logic signed [MX_W-1:0] hx;
    logic signed [MX_W-1:0] hy;
    logic signed [MX_W-1:0] cx;
    logic signed [MX_W-1:0] cy;
    logic [SCOL_W-1:0]      src_col_next;
    logic [SROW_W-1:0]      src_row_next;
    logic [PIX_W-1:0]       dst_row_next;
    logic                   done_reg;
    logic [SCOL_W-1:0]      src_col_reg;
    logic [SROW_W-1:0]      src_row_reg;
    logic [PIX_W-1:0]       dst_row_reg;

    always_comb
    begin
        qx = ((px_reg < 0) ? px_reg + RND_M : px_reg) >>> (ANGLE_BITS + 1);
        qy = ((py_reg < 0) ? py_reg + RND_M : py_reg) >>> (ANGLE_BITS + 1);
        hx = MX_W'(width_reg) - MX_W'(1);
        if (hx > COL_CAP)
        begin
            hx = COL_CAP;
        end
        hy = (height_reg == '0) ? '0 : MX_W'(height_reg) - MX_W'(1);
        if (hy > ROW_CAP)
        begin
            hy = ROW_CAP;
        end
        cx = (qx < 0) ? '0 : ((qx > hx) ? hx : qx);
        cy = (qy < 0) ? '0 : ((qy > hy) ? hy : qy);
        if (mul_reg.zero)
        begin
            src_col_next = '0;
            src_row_next = '0;
            dst_row_next = '0;
        end
        else
        begin
            src_col_next = cx[SCOL_W-1:0];
            src_row_next = cy[SROW_W-1:0];
            dst_row_next = mul_reg.dst_row;
        end
    end

    always_ff @(posedge clk)
    begin
        src_col_reg <= src_col_next;
        src_row_reg <= src_row_next;
        dst_row_reg <= dst_row_next;
    end

    // Valid bits ride with the data; reset empties the whole pipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            dv_reg    <= '0;
            cmb_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[P_LAST-1:0], accept};
            dv_reg    <= {dv_reg[CORDIC_STEPS-1:0], v_reg[P_LAST]};
            cmb_v_reg <= dv_reg[CORDIC_STEPS];
            mul_v_reg <= cmb_v_reg;
            done_reg  <= mul_v_reg;
        end
    end

    assign done    = done_reg;
    assign src_col = src_col_reg;
    assign src_row = src_row_reg;
    assign dst_row = dst_row_reg;

endmodule

// File: hdl/eqc_checker.sv
// Port-level checker for the cubemap address generator, bound to the top level.
module eqc_checker
    import eqc_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    localparam int LAT = PIPE_FIXED + CORDIC_STEPS;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching start");

    a_reset_empties: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe straight after reset");

    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == ADDR_IMAGE_WIDTH)
        ##1 (psel && !pwrite && paddr == ADDR_IMAGE_WIDTH)
        |-> prdata[CFG_W_W-1:0] == $past(pwdata[CFG_W_W-1:0]))
        else $error("image width read back wrong");

endmodule

bind equirect_to_cubemap_sample_address eqc_checker u_eqc_checker (.*);
